// ===== design/chebyshev_series_eval_with_derivatives_assert.svh =====
// Assertion helpers used by the checker file of this block.
`ifndef CHEBYSHEV_SERIES_EVAL_WITH_DERIVATIVES_ASSERT_SVH
`define CHEBYSHEV_SERIES_EVAL_WITH_DERIVATIVES_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CSE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/cse_pkg.sv =====
`default_nettype none

package cse_pkg;

  // Table size and divider step count.
  localparam int MaxTerms = 16;
  localparam int DivSteps = 63;

  // Result status codes.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_DOMAIN = 2'd1;
  localparam logic [1:0] ST_OVF    = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MIN   = 2'd0;
  localparam logic [1:0] CFG_MAX   = 2'd1;
  localparam logic [1:0] CFG_TERMS = 2'd2;

  // Product scaling codes for the shared multiplier.
  localparam logic [1:0] SH_29 = 2'd0;
  localparam logic [1:0] SH_30 = 2'd1;
  localparam logic [1:0] SH_32 = 2'd2;

  typedef struct packed {
    logic       start;
    logic [1:0] sh;
    logic       narrow;
  } mul_req_t;

  typedef struct packed {
    logic               done;
    logic               ovf;
    logic signed [63:0] value;
  } mul_rsp_t;

endpackage

`default_nettype wire

// ===== design/cse_chan_if.sv =====
`default_nettype none

// Input item channel.
interface cse_req_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [3:0]         coeff_index;
  logic signed [47:0] coeff_value;
  logic [31:0]        temperature;
  modport source(output valid, kind, coeff_index, coeff_value, temperature, input ready);
  modport sink(input valid, kind, coeff_index, coeff_value, temperature, output ready);
endinterface

// Result item channel.
interface cse_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [47:0] series_value;
  logic signed [47:0] first_deriv;
  logic signed [47:0] second_deriv;
  modport source(output valid, status, series_value, first_deriv, second_deriv, input ready);
  modport sink(input valid, status, series_value, first_deriv, second_deriv, output ready);
endinterface

// Configuration write channel.
interface cse_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== design/cse_mul.sv =====
`default_nettype none

// Serial signed multiply with truncating scale and range check.
// One 32x32 partial product per cycle until all four are summed, then the sum is scaled and registered.
module cse_mul (
  input  logic               clk,
  input  logic               rst,
  input  cse_pkg::mul_req_t  req,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  output cse_pkg::mul_rsp_t  rsp
);

  logic [63:0]  ua;
  logic [63:0]  ub;
  logic         neg;
  logic [127:0] acc;
  logic [1:0]   cnt;
  logic         busy;
  logic         fin;
  logic [1:0]   sh;
  logic         narrow;

  logic [31:0]  asel;
  logic [31:0]  bsel;
  logic [63:0]  pp;
  logic [127:0] pp_sh;
  logic [127:0] shv;
  logic [127:0] bound;

  // Partial product selection and alignment.
  always_comb begin
    asel = cnt[1] ? ua[63:32] : ua[31:0];
    bsel = cnt[0] ? ub[63:32] : ub[31:0];
    pp = asel * bsel;
    case (cnt)
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
  end

  // Scaling of the finished magnitude and the bound it must stay within.
  always_comb begin
    case (sh)
      cse_pkg::SH_29: shv = acc >> 29;
      cse_pkg::SH_30: shv = acc >> 30;
      default:        shv = acc >> 32;
    endcase
    bound = narrow ? (128'd1 << 47) : (128'd1 << 62);
  end

  // Sequencing of the partial products and the registered result.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      fin      <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        ua     <= a[63] ? (~a + 64'd1) : a;
        ub     <= b[63] ? (~b + 64'd1) : b;
        neg    <= a[63] ^ b[63];
        acc    <= '0;
        cnt    <= 2'd0;
        busy   <= 1'b1;
        sh     <= req.sh;
        narrow <= req.narrow;
      end else if (busy) begin
        acc <= acc + pp_sh;
        cnt <= cnt + 2'd1;
        if (cnt == 2'd3) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        fin       <= 1'b0;
        rsp.done  <= 1'b1;
        rsp.ovf   <= (shv > bound) || (!neg && (shv == bound));
        rsp.value <= neg ? (~shv[63:0] + 64'd1) : shv[63:0];
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/chebyshev_series_eval_with_derivatives.sv =====
// Channel  Direction  Carries
// req      in         kind, coeff_index, coeff_value, temperature
// rsp      out        status, series_value, first_deriv, second_deriv
// cfg      in         index, data (min_temperature, max_temperature, term_count)
//
// A load item, or an evaluate item that fails the checks, yields its result in the next cycle.
// A valid evaluate item runs the 63 steps of the restoring divider, then
// 3 * term_count + 3 products on the shared 32x32 multiplier.
// The block takes no new item while an evaluation runs.
// Reset (rst, synchronous) clears the state, the configuration, the output valid flag and the coefficient table.
// A waiting result holds in the output register; a new item is taken while it drains.
`default_nettype none

module chebyshev_series_eval_with_derivatives (
  input logic clk,
  input logic rst,
  cse_req_if.sink   req,
  cse_rsp_if.source rsp,
  cse_cfg_if.sink   cfg
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_MAP  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_WAIT = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  localparam logic [2:0] P_LOOP  = 3'd0;
  localparam logic [2:0] P_FINAL = 3'd1;
  localparam logic [2:0] P_D1    = 3'd2;
  localparam logic [2:0] P_T     = 3'd3;
  localparam logic [2:0] P_D2    = 3'd4;

  logic [31:0]        min_t;
  logic [31:0]        max_t;
  logic [4:0]         term_cnt;
  logic signed [47:0] coeff_tab [cse_pkg::MaxTerms];

  logic [2:0]         st;
  logic [2:0]         phase;
  logic [1:0]         op;
  logic [3:0]         k;
  logic [5:0]         div_cnt;
  logic [31:0]        range;
  logic [31:0]        r1;
  logic [31:0]        r2;
  logic [62:0]        n1;
  logic [62:0]        n2;
  logic signed [31:0] x;
  logic [53:0]        s;
  logic signed [63:0] bn, bnn, fn, fnn, sn, snn;
  logic signed [63:0] pr0, pr1;
  logic signed [63:0] val, d1x, d2x, t_r, first_r, second_r;
  logic               ovf;

  logic               accept;
  logic               cfg_bad;
  logic               out_free;
  logic [32:0]        r1s, r2s;
  logic               ge1, ge2;
  logic signed [33:0] xw;
  logic signed [31:0] x_clamp;
  logic signed [63:0] ck;
  logic signed [63:0] cv, cf, cs;
  logic               upd_ovf;
  logic signed [63:0] ma, mb;
  cse_pkg::mul_req_t  mreq;
  cse_pkg::mul_rsp_t  mrsp;

  function automatic logic fits60(input logic signed [63:0] v);
    return (v[63:59] == 5'b00000) || (v[63:59] == 5'b11111);
  endfunction

  function automatic logic fits48(input logic signed [63:0] v);
    return (v[63:47] == 17'd0) || (v[63:47] == {17{1'b1}});
  endfunction

  // Handshakes.
  assign out_free   = !rsp.valid || rsp.ready;
  assign req.ready  = (st == S_IDLE) && out_free;
  assign accept     = req.valid && req.ready;
  assign cfg.ready  = 1'b1;

  // Configuration and domain checks for an evaluate item.
  assign cfg_bad = (min_t == 32'd0) || (max_t <= min_t) || (term_cnt == 5'd0) ||
                   (term_cnt > 5'(cse_pkg::MaxTerms)) ||
                   (req.temperature < min_t) || (req.temperature > max_t);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_t    <= '0;
      max_t    <= '0;
      term_cnt <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        cse_pkg::CFG_MIN:   min_t    <= cfg.data;
        cse_pkg::CFG_MAX:   max_t    <= cfg.data;
        cse_pkg::CFG_TERMS: term_cnt <= cfg.data[4:0];
        default: ;
      endcase
    end
  end

  // Coefficient table.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < cse_pkg::MaxTerms; i++) begin
        coeff_tab[i] <= '0;
      end
    end else if (accept && !req.kind) begin
      coeff_tab[req.coeff_index] <= req.coeff_value;
    end
  end

  // One restoring step of each divider: (T - min) * 2^31 / range and 2^53 / range.
  always_comb begin
    r1s = {r1, n1[62]};
    r2s = {r2, n2[62]};
    ge1 = r1s >= {1'b0, range};
    ge2 = r2s >= {1'b0, range};
  end

  // Map the quotient to x and clamp to [-1, 1].
  always_comb begin
    xw = $signed({2'b00, n1[31:0]}) - 34'sd1073741824;
    if (xw > 34'sd1073741824) begin
      x_clamp = 32'sd1073741824;
    end else if (xw < -34'sd1073741824) begin
      x_clamp = -32'sd1073741824;
    end else begin
      x_clamp = 32'(xw);
    end
  end

  // Clenshaw recurrence update, shared by the loop and the final step.
  always_comb begin
    ck = {{16{coeff_tab[k][47]}}, coeff_tab[k]};
    cv = pr0 - bnn + ck;
    if (phase == P_FINAL) begin
      cf = bn + pr1 - fnn;
      cs = (fn <<< 1) + mrsp.value - snn;
      upd_ovf = !fits48(cv) || !fits60(cf) || !fits60(cs);
    end else begin
      cf = (bn <<< 1) + pr1 - fnn;
      cs = (fn <<< 2) + mrsp.value - snn;
      upd_ovf = !fits60(cv) || !fits60(cf) || !fits60(cs);
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    ma = {{32{x[31]}}, x};
    mb = bn;
    mreq.sh = cse_pkg::SH_32;
    case (phase)
      P_LOOP, P_FINAL: begin
        mreq.sh = (phase == P_LOOP) ? cse_pkg::SH_29 : cse_pkg::SH_30;
        case (op)
          2'd0:    mb = bn;
          2'd1:    mb = fn;
          default: mb = sn;
        endcase
      end
      P_D1: begin
        ma = d1x;
        mb = {10'd0, s};
      end
      P_T: begin
        ma = d2x;
        mb = {10'd0, s};
      end
      default: begin
        ma = t_r;
        mb = {10'd0, s};
      end
    endcase
    mreq.start  = (st == S_MUL);
    mreq.narrow = (phase == P_D1) || (phase == P_D2);
  end

  cse_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .a   (ma),
    .b   (mb),
    .rsp (mrsp)
  );

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
    end else begin
      case (st)
        S_IDLE: begin
          if (accept && req.kind && !cfg_bad) begin
            range   <= max_t - min_t;
            r1      <= '0;
            r2      <= '0;
            n1      <= {req.temperature - min_t, 31'd0};
            n2      <= 63'd1 << 53;
            div_cnt <= '0;
            st      <= S_DIV;
          end
        end
        S_DIV: begin
          r1      <= ge1 ? 32'(r1s - {1'b0, range}) : r1s[31:0];
          r2      <= ge2 ? 32'(r2s - {1'b0, range}) : r2s[31:0];
          n1      <= {n1[61:0], ge1};
          n2      <= {n2[61:0], ge2};
          div_cnt <= div_cnt + 6'd1;
          if (div_cnt == 6'(cse_pkg::DivSteps - 1)) begin
            st <= S_MAP;
          end
        end
        S_MAP: begin
          x   <= x_clamp;
          s   <= n2[53:0];
          bn  <= '0;
          bnn <= '0;
          fn  <= '0;
          fnn <= '0;
          sn  <= '0;
          snn <= '0;
          ovf <= 1'b0;
          op  <= 2'd0;
          k   <= 4'(term_cnt - 5'd1);
          phase <= (term_cnt == 5'd1) ? P_FINAL : P_LOOP;
          st  <= S_MUL;
        end
        S_MUL: begin
          st <= S_WAIT;
        end
        S_WAIT: begin
          if (mrsp.done) begin
            st <= S_MUL;
            case (phase)
              P_LOOP, P_FINAL: begin
                case (op)
                  2'd0: begin
                    pr0 <= mrsp.value;
                    ovf <= ovf | mrsp.ovf;
                    op  <= 2'd1;
                  end
                  2'd1: begin
                    pr1 <= mrsp.value;
                    ovf <= ovf | mrsp.ovf;
                    op  <= 2'd2;
                  end
                  default: begin
                    ovf <= ovf | mrsp.ovf | upd_ovf;
                    op  <= 2'd0;
                    if (phase == P_FINAL) begin
                      val   <= cv;
                      d1x   <= cf;
                      d2x   <= cs;
                      phase <= P_D1;
                    end else begin
                      bnn <= bn;
                      bn  <= cv;
                      fnn <= fn;
                      fn  <= cf;
                      snn <= sn;
                      sn  <= cs;
                      k   <= k - 4'd1;
                      if (k == 4'd1) begin
                        phase <= P_FINAL;
                      end
                    end
                  end
                endcase
              end
              P_D1: begin
                first_r <= mrsp.value;
                ovf     <= ovf | mrsp.ovf;
                phase   <= P_T;
              end
              P_T: begin
                t_r   <= mrsp.value;
                ovf   <= ovf | mrsp.ovf;
                phase <= P_D2;
              end
              default: begin
                second_r <= mrsp.value;
                ovf      <= ovf | mrsp.ovf;
                st       <= S_OUT;
              end
            endcase
          end
        end
        S_OUT: begin
          if (out_free) begin
            st <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      if (accept && (!req.kind || cfg_bad)) begin
        rsp.valid        <= 1'b1;
        rsp.status       <= req.kind ? cse_pkg::ST_DOMAIN : cse_pkg::ST_OK;
        rsp.series_value <= '0;
        rsp.first_deriv  <= '0;
        rsp.second_deriv <= '0;
      end else if ((st == S_OUT) && out_free) begin
        rsp.valid        <= 1'b1;
        rsp.status       <= ovf ? cse_pkg::ST_OVF : cse_pkg::ST_OK;
        rsp.series_value <= ovf ? 48'sd0 : val[47:0];
        rsp.first_deriv  <= ovf ? 48'sd0 : first_r[47:0];
        rsp.second_deriv <= ovf ? 48'sd0 : second_r[47:0];
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/cse_checker.sv =====
`default_nettype none
`include "chebyshev_series_eval_with_derivatives_assert.svh"

// Port-level checks on the evaluator.
module cse_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        req_kind,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [1:0]  rsp_status,
  input logic [47:0] rsp_series_value,
  input logic [47:0] rsp_first_deriv,
  input logic [47:0] rsp_second_deriv
);

  logic         vals_zero;
  logic [145:0] rsp_payload;

  // Result payload views used by the checks below.
  assign vals_zero   = (rsp_series_value == 48'd0) && (rsp_first_deriv == 48'd0) &&
                       (rsp_second_deriv == 48'd0);
  assign rsp_payload = {rsp_status, rsp_series_value, rsp_first_deriv, rsp_second_deriv};

  // A result beat held back by the sink stays offered.
  `CSE_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")

  // A failed result carries zero values.
  `CSE_ASSERT_SAME(a_fail_zero, rsp_valid && (rsp_status != cse_pkg::ST_OK), vals_zero, "nonzero values on failed result")

  // A load beat yields its result in the following cycle.
  `CSE_ASSERT_NEXT(a_load_rsp, req_valid && req_ready && !req_kind, rsp_valid && (rsp_status == cse_pkg::ST_OK), "load result missing")

  // A result beat held back by the sink keeps its payload.
  `CSE_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_payload), "result changed while stalled")

endmodule

bind chebyshev_series_eval_with_derivatives cse_checker u_cse_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .req_kind         (req.kind),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_status       (rsp.status),
  .rsp_series_value (rsp.series_value),
  .rsp_first_deriv  (rsp.first_deriv),
  .rsp_second_deriv (rsp.second_deriv)
);

`default_nettype wire
